// File: hdl/tlnf_pkg.sv
`default_nettype none
package tlnf_pkg;

  // default width of the line counter in decimal digits
  localparam int COUNT_DIGITS_DEF = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CONTROLS   = 3'd5;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_LIM  = 8'h20;
  localparam logic [7:0] CARET_XOR = 8'h40;

  // squeeze keeps at most this many newlines in a row
  localparam logic [1:0] NL_RUN_MAX = 2'd2;

  // option bits
  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_controls;
  } opts_t;

endpackage
`default_nettype wire

// File: hdl/text_line_number_filter.sv
`default_nettype none
// latency: first output byte of an item is valid the cycle after its input transfer
// throughput: one output byte per cycle while out_stall is low; an item emits
//   1 to COUNT_DIGITS+4 bytes from the single output byte register walking the run slots
// a squeezed newline is absorbed in its input cycle and emits nothing
// synchronous active-low reset clears options, the newline run and the output run valid;
//   the line count resets to 1 and the line-start flag is set
module text_line_number_filter #(
  parameter int COUNT_DIGITS = tlnf_pkg::COUNT_DIGITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_file_start,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_run_last,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                           cfg_data
);

  localparam int CNT_W = 4 * COUNT_DIGITS;
  localparam int SLOTS = COUNT_DIGITS + 4;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] PRE_IDX  = IDX_W'(SLOTS - 2);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  tlnf_pkg::opts_t  opts_r;
  logic             line_start_r, line_start_nxt;
  logic [1:0]       nl_run_r, nl_run_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             run_valid_r, run_valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             has_pre_r;
  logic [7:0]       slot_r [SLOTS];
  logic [7:0]       slot_nxt [SLOTS];
  logic [IDX_W-1:0] start_idx;
  logic             has_pre;

  logic             in_xfer, out_xfer, run_done;
  logic             nl, drop, num;
  logic             eff_start;
  logic [1:0]       eff_run;
  logic [CNT_W-1:0] eff_cnt, cnt_inc;
  logic             nz_above;
  logic             carry;
  logic [3:0]       dig;
  logic [3:0]       inc_dig;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opts_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlnf_pkg::CFG_NUMBER_ALL:      opts_r.number_all      <= cfg_data;
        tlnf_pkg::CFG_NUMBER_NONBLANK: opts_r.number_nonblank <= cfg_data;
        tlnf_pkg::CFG_SQUEEZE_BLANK:   opts_r.squeeze_blank   <= cfg_data;
        tlnf_pkg::CFG_SHOW_ENDS:       opts_r.show_ends       <= cfg_data;
        tlnf_pkg::CFG_SHOW_TABS:       opts_r.show_tabs       <= cfg_data;
        tlnf_pkg::CFG_SHOW_CONTROLS:   opts_r.show_controls   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_valid    = run_valid_r;
  assign out_xfer     = run_valid_r && !out_stall;
  assign run_done     = out_xfer && (idx_r == LAST_IDX);
  assign in_stall     = run_valid_r && !run_done;
  assign in_xfer      = in_valid && !in_stall;
  assign out_byte     = slot_r[idx_r];
  assign out_run_last = (idx_r == LAST_IDX);

  // line state after a file start
  always_comb begin
    eff_start = in_file_start ? 1'b1 : line_start_r;
    eff_run   = in_file_start ? 2'd0 : nl_run_r;
    eff_cnt   = in_file_start ? CNT_ONE : cnt_r;
  end

  // bcd increment with wrap
  always_comb begin
    cnt_inc = eff_cnt;
    carry   = 1'b1;
    for (int p = 0; p < COUNT_DIGITS; p++) begin
      inc_dig = eff_cnt[4*p +: 4];
      if (carry) begin
        if (inc_dig >= 4'd9) begin
          cnt_inc[4*p +: 4] = 4'd0;
        end else begin
          cnt_inc[4*p +: 4] = inc_dig + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // item decode and run build
  always_comb begin
    nl   = (in_byte == tlnf_pkg::CH_NL);
    drop = opts_r.squeeze_blank && nl && (eff_run >= tlnf_pkg::NL_RUN_MAX);
    num  = eff_start && (opts_r.number_nonblank ? !nl : opts_r.number_all);

    if (opts_r.squeeze_blank && nl) begin
      nl_run_nxt = drop ? eff_run : eff_run + 2'd1;
    end else begin
      nl_run_nxt = 2'd0;
    end
    line_start_nxt = drop ? eff_start : nl;
    cnt_nxt        = (!drop && num) ? cnt_inc : eff_cnt;

    // number prefix, leading zeros blanked, last digit always shown
    nz_above = 1'b0;
    for (int p = COUNT_DIGITS - 1; p >= 0; p--) begin
      dig = eff_cnt[4*p +: 4];
      if (dig != 4'd0 || p == 0) begin
        nz_above = 1'b1;
      end
      slot_nxt[COUNT_DIGITS-1-p] = nz_above ? (tlnf_pkg::CH_ZERO | {4'd0, dig})
                                            : tlnf_pkg::CH_SPACE;
    end
    slot_nxt[COUNT_DIGITS]     = tlnf_pkg::CH_SPACE;
    slot_nxt[COUNT_DIGITS + 1] = tlnf_pkg::CH_SPACE;

    // escape or end marker, then the byte
    has_pre = 1'b1;
    priority if (nl) begin
      has_pre           = opts_r.show_ends;
      slot_nxt[PRE_IDX]  = tlnf_pkg::CH_DOLLAR;
      slot_nxt[LAST_IDX] = tlnf_pkg::CH_NL;
    end else if (in_byte == tlnf_pkg::CH_TAB && opts_r.show_tabs) begin
      slot_nxt[PRE_IDX]  = tlnf_pkg::CH_CARET;
      slot_nxt[LAST_IDX] = tlnf_pkg::CH_I;
    end else if (opts_r.show_controls && in_byte != tlnf_pkg::CH_TAB &&
                 (in_byte < tlnf_pkg::CTRL_LIM || in_byte == tlnf_pkg::CH_DEL)) begin
      slot_nxt[PRE_IDX]  = tlnf_pkg::CH_CARET;
      slot_nxt[LAST_IDX] = in_byte ^ tlnf_pkg::CARET_XOR;
    end else begin
      has_pre           = 1'b0;
      slot_nxt[PRE_IDX]  = tlnf_pkg::CH_CARET;
      slot_nxt[LAST_IDX] = in_byte;
    end

    if (num) begin
      start_idx = '0;
    end else begin
      start_idx = has_pre ? PRE_IDX : LAST_IDX;
    end
  end

  // run sequencing
  always_comb begin
    run_valid_nxt = run_valid_r;
    idx_nxt       = idx_r;
    if (in_xfer && !drop) begin
      run_valid_nxt = 1'b1;
      idx_nxt       = start_idx;
    end else if (run_done) begin
      run_valid_nxt = 1'b0;
    end else if (out_xfer) begin
      if (idx_r + IDX_W'(1) == PRE_IDX && !has_pre_r) begin
        idx_nxt = LAST_IDX;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // control and line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r  <= 1'b0;
      idx_r        <= '0;
      line_start_r <= 1'b1;
      nl_run_r     <= 2'd0;
      cnt_r        <= CNT_ONE;
    end else begin
      run_valid_r <= run_valid_nxt;
      idx_r       <= idx_nxt;
      if (in_xfer) begin
        line_start_r <= line_start_nxt;
        nl_run_r     <= nl_run_nxt;
        cnt_r        <= cnt_nxt;
      end
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (in_xfer && !drop) begin
      has_pre_r <= has_pre;
      for (int s = 0; s < SLOTS; s++) begin
        slot_r[s] <= slot_nxt[s];
      end
    end
  end

  // no input transfer while a run is still being sent
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && run_valid_r && !run_done))
    else $error("input transfer during an unfinished run");

  // a stalled output holds its position in the run
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(idx_r)))
    else $error("run position moved under stall");

  // the line count only moves on an input transfer
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(cnt_r))
    else $error("line count changed without a transfer");

  // squeeze run never exceeds its limit
  a_nl_run: assert property (@(posedge clk) disable iff (!rst_n)
    nl_run_r <= tlnf_pkg::NL_RUN_MAX)
    else $error("newline run out of range");

  // a run without an escape skips the escape slot
  a_pre_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (run_valid_r && !has_pre_r) |-> (idx_r != PRE_IDX))
    else $error("empty escape slot emitted");

endmodule
`default_nettype wire

// File: tb/tb_text_line_number_filter.sv
`default_nettype none
module tb_text_line_number_filter;

  // full-width count, as the block is used
  localparam int NDIG     = tlnf_pkg::COUNT_DIGITS_DEF;
  localparam int SETTLE   = NDIG + 8;
  localparam int HOLD_CYC = 80;
  localparam int QUIET_MAX = 1000;

  typedef struct packed {
    logic [7:0] ch;
    logic       fs;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic in_file_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_run_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  text_line_number_filter #(.COUNT_DIGITS(NDIG)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .in_file_start(in_file_start),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_run_last(out_run_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  wire in_xfer  = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;
  wire cfg_xfer = cfg_valid && cfg_ready;

  text_item_t text_to_send[$];
  out_rec_t   out_bytes_due[$];

  // shadow of options and line state
  tlnf_pkg::opts_t       opt_sh = '0;
  logic                  line_start = 1'b1;
  logic [1:0]            nl_streak = 2'd0;
  logic [4*NDIG-1:0]     line_bcd = (4*NDIG)'(1);

  logic idle_on = 1'b1;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int   in_gap = 0;
  int   rx_left = 0;
  int   quiet_cnt = 0;
  int   bad_cnt = 0;
  text_item_t nxt_item;
  out_rec_t   due_rec;

  // expected output run for one accepted text byte
  task automatic filter_byte(input logic [7:0] b, input logic fs);
    logic [7:0] run [0:NDIG+3];
    int   n;
    logic is_nl;
    logic lead;
    logic carry;
    logic [3:0] d;
    out_rec_t rec;
    n = 0;
    is_nl = (b == tlnf_pkg::CH_NL);
    if (fs) begin
      line_start = 1'b1;
      nl_streak = 2'd0;
      line_bcd = (4*NDIG)'(1);
    end
    // squeeze drops newlines past the second in a row
    if (opt_sh.squeeze_blank && is_nl) begin
      if (nl_streak >= tlnf_pkg::NL_RUN_MAX) return;
      nl_streak = nl_streak + 2'd1;
    end else begin
      nl_streak = 2'd0;
    end
    // line number prefix
    if (line_start) begin
      if (opt_sh.number_nonblank ? !is_nl : opt_sh.number_all) begin
        lead = 1'b1;
        for (int p = NDIG - 1; p >= 0; p--) begin
          d = line_bcd[4*p +: 4];
          if (d != 4'd0 || p == 0) lead = 1'b0;
          run[n] = lead ? tlnf_pkg::CH_SPACE : (tlnf_pkg::CH_ZERO + {4'd0, d});
          n++;
        end
        run[n] = tlnf_pkg::CH_SPACE;
        run[n+1] = tlnf_pkg::CH_SPACE;
        n += 2;
        carry = 1'b1;
        for (int p = 0; p < NDIG; p++) begin
          if (carry) begin
            if (line_bcd[4*p +: 4] == 4'd9) begin
              line_bcd[4*p +: 4] = 4'd0;
            end else begin
              line_bcd[4*p +: 4] = line_bcd[4*p +: 4] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
      line_start = 1'b0;
    end
    // the byte itself, possibly escaped
    if (is_nl) begin
      if (opt_sh.show_ends) begin
        run[n] = tlnf_pkg::CH_DOLLAR;
        n++;
      end
      run[n] = tlnf_pkg::CH_NL;
      n++;
      line_start = 1'b1;
    end else if (b == tlnf_pkg::CH_TAB && opt_sh.show_tabs) begin
      run[n] = tlnf_pkg::CH_CARET;
      run[n+1] = tlnf_pkg::CH_I;
      n += 2;
    end else if (opt_sh.show_controls && b != tlnf_pkg::CH_TAB &&
                 (b < tlnf_pkg::CTRL_LIM || b == tlnf_pkg::CH_DEL)) begin
      run[n] = tlnf_pkg::CH_CARET;
      run[n+1] = b ^ tlnf_pkg::CARET_XOR;
      n += 2;
    end else begin
      run[n] = b;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      rec.ch = run[i];
      rec.last = (i == n - 1);
      out_bytes_due.push_back(rec);
    end
  endtask

  // sender: one text byte per transfer, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_xfer) filter_byte(in_byte, in_file_start);
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (text_to_send.size() != 0) begin
          nxt_item = text_to_send.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt_item.ch;
          in_file_start <= nxt_item.fs;
          if (idle_on && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random bursts and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_left <= 0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      rx_left <= HOLD_CYC - 1;
      out_stall <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // output check against the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_xfer) begin
      if (out_bytes_due.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected output byte %02h last %0b", out_byte, out_run_last);
      end else begin
        due_rec = out_bytes_due.pop_front();
        if (out_byte !== due_rec.ch || out_run_last !== due_rec.last) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                     due_rec.ch, out_byte, due_rec.last, out_run_last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || in_xfer || out_xfer || cfg_xfer) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic write_reg(input logic [tlnf_pkg::CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_opts(input tlnf_pkg::opts_t o);
    write_reg(tlnf_pkg::CFG_NUMBER_ALL, o.number_all);
    write_reg(tlnf_pkg::CFG_NUMBER_NONBLANK, o.number_nonblank);
    write_reg(tlnf_pkg::CFG_SQUEEZE_BLANK, o.squeeze_blank);
    write_reg(tlnf_pkg::CFG_SHOW_ENDS, o.show_ends);
    write_reg(tlnf_pkg::CFG_SHOW_TABS, o.show_tabs);
    write_reg(tlnf_pkg::CFG_SHOW_CONTROLS, o.show_controls);
    opt_sh = o;
    @(negedge clk);
  endtask

  task automatic queue_item(input logic [7:0] ch, input logic fs);
    text_item_t it;
    it.ch = ch;
    it.fs = fs;
    text_to_send.push_back(it);
  endtask

  // all sent, all results back, then room for a squeezed newline in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (text_to_send.size() != 0 || in_valid || out_bytes_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0: return tlnf_pkg::CH_TAB;
      1: return ($urandom_range(0, 8) == 0) ? tlnf_pkg::CH_DEL : 8'($urandom_range(0, 31));
      2: return 8'($urandom_range(128, 255));
      3: return 8'($urandom());
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // lines of random content, runs of blank lines, occasional new file
  task automatic queue_text(input int n_items, input int max_len, input int fs_odds);
    int   cnt;
    int   len;
    logic fs;
    cnt = 0;
    while (cnt < n_items) begin
      fs = (fs_odds != 0) && ($urandom_range(1, fs_odds) == 1);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          queue_item(tlnf_pkg::CH_NL, fs);
          fs = 1'b0;
          cnt++;
        end
      end else begin
        len = $urandom_range(0, max_len);
        repeat (len) begin
          queue_item(rand_char(), fs);
          fs = 1'b0;
          cnt++;
        end
        queue_item(tlnf_pkg::CH_NL, fs);
        cnt++;
      end
    end
  endtask

  // option order in opts_t, msb first:
  // number_all, number_nonblank, squeeze_blank, show_ends, show_tabs, show_controls
  initial begin
    tlnf_pkg::opts_t o;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // plain pass-through, byte extremes
    set_opts(6'b000000);
    queue_item(8'h00, 1'b1);
    queue_item(8'hFF, 1'b0);
    queue_item(tlnf_pkg::CH_DEL, 1'b0);
    queue_item(tlnf_pkg::CH_TAB, 1'b0);
    queue_item(8'h61, 1'b0);
    queue_item(tlnf_pkg::CH_NL, 1'b0);
    wait_drained();

    // numbering, squeeze, ends, tabs, controls together
    set_opts(6'b101111);
    queue_item(8'h41, 1'b1);
    queue_item(tlnf_pkg::CH_TAB, 1'b0);
    queue_item(8'h01, 1'b0);
    queue_item(tlnf_pkg::CH_DEL, 1'b0);
    queue_item(8'h80, 1'b0);
    queue_item(8'hFF, 1'b0);
    repeat (4) queue_item(tlnf_pkg::CH_NL, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(tlnf_pkg::CH_NL, 1'b0);
    wait_drained();

    // nonblank over all, tab untouched by controls alone
    set_opts(6'b110001);
    queue_item(8'h78, 1'b1);
    queue_item(tlnf_pkg::CH_NL, 1'b0);
    queue_item(tlnf_pkg::CH_NL, 1'b0);
    queue_item(tlnf_pkg::CH_TAB, 1'b0);
    queue_item(8'h1F, 1'b0);
    queue_item(tlnf_pkg::CH_NL, 1'b0);
    wait_drained();

    // random text under several option sets
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: o = 6'b111111;
        1: o = 6'b000000;
        default: o = 6'($urandom_range(0, 63));
      endcase
      set_opts(o);
      idle_on = (ph != 3);
      queue_text(25, 8, 16);
      if (ph == 2) hold_go = 1'b1;
      wait_drained();
    end

    // one long file of short lines so the count runs into two digits
    idle_on = 1'b1;
    set_opts(6'b100000);
    queue_item(tlnf_pkg::CH_NL, 1'b1);
    queue_text(80, 1, 0);
    wait_drained();

    // closing stretch without idling
    idle_on = 1'b0;
    set_opts(6'b011111);
    queue_text(25, 8, 16);
    wait_drained();

    if (bad_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
